// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the delay line RTL.
// Each macro expects signals named clk and rst_n in the calling module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define FDLA_CHECK(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define FDLA_CHECK_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define FDLA_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fdla_pkg.sv =====
// ----------------------------------------------------------------------------
// fdla_pkg
// Types, codes and sizes shared by the fractional delay line modules.
// ----------------------------------------------------------------------------
package fdla_pkg;

    // ring size: a power of two, so the average is a plain shift of the sum
    localparam int DEPTH_DEFAULT = 1024;

    localparam int SAMPLE_W = 16;
    localparam int WHOLE_W  = 10;
    localparam int FRAC_W   = 8;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = DIFF_W + FRAC_W;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_WHOLE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_FRACTION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_VALUE     = 2'd2;

    // item kinds
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // queues
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 2;
    localparam int MID_LEVEL_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_LEVEL_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] delayed;
        logic signed [SAMPLE_W-1:0] average;
        logic                       warming;
    } result_t;

    typedef struct packed {
        logic        [WHOLE_W-1:0]  delay_whole;
        logic        [FRAC_W-1:0]   delay_fraction;
        logic signed [SAMPLE_W-1:0] init_value;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                       kind;
        logic                       warming;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] old;
        logic signed [SAMPLE_W-1:0] tap_near;
        logic signed [DIFF_W-1:0]   tap_diff;
    } work_t;

endpackage

// ===== hw/rtl/fdla_ram.sv =====
// ----------------------------------------------------------------------------
// fdla_ram
// Simple dual-port RAM, one write and one registered read, read-first.
// ----------------------------------------------------------------------------
module fdla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/fdla_fifo.sv =====
// ----------------------------------------------------------------------------
// fdla_fifo
// Small register FIFO; the writer keeps track of room through level.
// ----------------------------------------------------------------------------
module fdla_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] storage_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;
    logic             do_pop;

    assign empty    = (level_reg == '0);
    assign level    = level_reg;
    assign pop_data = storage_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        level_next = level_reg + LW'(push) - LW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            storage_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/fdla_front.sv =====
// ----------------------------------------------------------------------------
// fdla_front
// Accept items, keep the ring position and fill count, read the taps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdla_front #(
    parameter int DEPTH = fdla_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  fdla_pkg::item_t                  item,
    output logic                             full,
    input  fdla_pkg::cfg_t                   cfg,
    output logic                             q_push,
    output fdla_pkg::work_t                  q_item,
    input  logic [fdla_pkg::MID_LEVEL_W-1:0] q_level
);

    import fdla_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int SW  = $clog2(DEPTH + 1);
    localparam int CW  = ((AW > WHOLE_W) ? AW : WHOLE_W) + 1;
    localparam int LVW = MID_LEVEL_W + 1;
    localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);
    localparam logic [AW-1:0] WRAP_ADD  = AW'(DEPTH);
    localparam logic [CW-1:0] DELAY_MAX = CW'(DEPTH - 2);
    localparam logic [SW-1:0] SEEN_FULL = SW'(DEPTH);

    logic [AW-1:0]              wp_reg, wp_next;
    logic [SW-1:0]              seen_reg, seen_next;
    logic signed [SAMPLE_W-1:0] fill_reg, fill_next;

    logic          accept;
    logic          is_restart;
    logic [LVW-1:0] pending;
    logic [CW-1:0] whole_ext, delay_sat, seen_ext;
    logic [AW-1:0] delay_pos, near_addr, far_addr;
    logic          near_ok, far_ok, old_ok, delay_zero, warming;

    logic                       s1_valid_reg;
    logic                       s1_kind_reg, s1_warming_reg;
    logic                       s1_old_ok_reg, s1_near_ok_reg, s1_far_ok_reg, s1_zero_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;

    logic [SAMPLE_W-1:0]        old_q, near_q, far_q;
    logic signed [SAMPLE_W-1:0] old_sel, near_sel, far_sel;

    // room for the item in flight through the RAM read
    assign pending    = LVW'(q_level) + LVW'(s1_valid_reg);
    assign full       = (pending >= LVW'(MID_DEPTH));
    assign accept     = push && !full;
    assign is_restart = (item.kind == KIND_RESTART);

    // classify against the delay, saturated below the ring size
    always_comb
    begin
        whole_ext  = CW'(cfg.delay_whole);
        delay_sat  = (whole_ext > DELAY_MAX) ? DELAY_MAX : whole_ext;
        delay_pos  = delay_sat[AW-1:0];
        seen_ext   = CW'(seen_reg);
        near_ok    = (delay_sat <= seen_ext);
        far_ok     = (delay_sat < seen_ext);
        old_ok     = (seen_reg == SEEN_FULL);
        delay_zero = (delay_sat == '0);
        warming    = (seen_ext < delay_sat)
                  || ((seen_ext == delay_sat) && (cfg.delay_fraction != '0));
        near_addr  = wp_reg - delay_pos + ((wp_reg < delay_pos) ? WRAP_ADD : '0);
        far_addr   = (near_addr == '0) ? LAST_POS : near_addr - 1'b1;
    end

    always_comb
    begin
        wp_next   = wp_reg;
        seen_next = seen_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            if (is_restart)
            begin
                wp_next   = '0;
                seen_next = '0;
                fill_next = cfg.init_value;
            end
            else
            begin
                wp_next   = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;
                seen_next = (seen_reg == SEEN_FULL) ? seen_reg : seen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            seen_reg     <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg       <= wp_next;
            seen_reg     <= seen_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg    <= item.kind;
            s1_warming_reg <= is_restart || warming;
            s1_sample_reg  <= item.sample;
            s1_old_ok_reg  <= old_ok;
            s1_near_ok_reg <= near_ok;
            s1_far_ok_reg  <= far_ok;
            s1_zero_reg    <= delay_zero;
        end
    end

    // three copies of the ring: slot being overwritten, near tap, far tap
    fdla_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_old (
        .clk     (clk),
        .wr_en   (accept && !is_restart),
        .wr_addr (wp_reg),
        .wr_data (item.sample),
        .rd_addr (wp_reg),
        .rd_data (old_q)
    );

    fdla_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_near (
        .clk     (clk),
        .wr_en   (accept && !is_restart),
        .wr_addr (wp_reg),
        .wr_data (item.sample),
        .rd_addr (near_addr),
        .rd_data (near_q)
    );

    fdla_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_far (
        .clk     (clk),
        .wr_en   (accept && !is_restart),
        .wr_addr (wp_reg),
        .wr_data (item.sample),
        .rd_addr (far_addr),
        .rd_data (far_q)
    );

    // unwritten slots read as the fill value; fill_reg only moves on a
    // restart, which needs no tap data
    always_comb
    begin
        old_sel  = s1_old_ok_reg ? $signed(old_q) : fill_reg;
        near_sel = s1_zero_reg ? s1_sample_reg
                 : (s1_near_ok_reg ? $signed(near_q) : fill_reg);
        far_sel  = s1_far_ok_reg ? $signed(far_q) : fill_reg;

        q_item.kind     = s1_kind_reg;
        q_item.warming  = s1_warming_reg;
        q_item.sample   = s1_sample_reg;
        q_item.old      = old_sel;
        q_item.tap_near = near_sel;
        q_item.tap_diff = DIFF_W'(far_sel) - DIFF_W'(near_sel);
    end

    assign q_push = s1_valid_reg;

    `FDLA_CHECK(seen_bounded, seen_reg <= SEEN_FULL, "fill count beyond ring size")
    `FDLA_CHECK_NEXT(restart_clears, accept && is_restart,
                     (wp_reg == '0) && (seen_reg == '0), "restart left history behind")
    `FDLA_CHECK_SAME(queue_room, s1_valid_reg, q_level < MID_LEVEL_W'(MID_DEPTH),
                     "mid queue overflow")

endmodule

// ===== hw/rtl/fdla_back.sv =====
// ----------------------------------------------------------------------------
// fdla_back
// Interpolate the taps, keep the running sum and take the ring average.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdla_back #(
    parameter int DEPTH = fdla_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fdla_pkg::cfg_t                   cfg,
    input  logic                             q_empty,
    output logic                             q_pop,
    input  fdla_pkg::work_t                  q_item,
    output logic                             out_push,
    output fdla_pkg::result_t                out_item,
    input  logic [fdla_pkg::OUT_LEVEL_W-1:0] out_level
);

    import fdla_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = SAMPLE_W + AW;
    localparam int ACC_W = PROD_W + 1;
    localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(DEPTH);
    localparam logic [SUM_W-1:0] BIAS    = DIVISOR << (SAMPLE_W - 1);
    localparam logic signed [SUM_W-1:0] SUM_LO = -$signed(BIAS);
    localparam logic signed [SUM_W-1:0] SUM_HI = $signed(BIAS - DIVISOR);

    logic adv;
    logic take;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] restart_sum;

    logic                       p1_valid_reg;
    logic                       p1_warming_reg;
    logic signed [SAMPLE_W-1:0] p1_near_reg;
    logic signed [PROD_W-1:0]   p1_prod_reg;
    logic signed [FRAC_W:0]     frac_s;

    logic signed [ACC_W-1:0]    acc;
    logic signed [SAMPLE_W-1:0] delayed_sel;

    // the whole pipe moves together while the output queue has room
    assign adv   = (out_level < OUT_LEVEL_W'(OUT_DEPTH));
    assign take  = adv && !q_empty;
    assign q_pop = take;

    assign frac_s = {1'b0, cfg.delay_fraction};

    always_comb
    begin
        restart_sum = {cfg.init_value, {AW{1'b0}}};
        sum_next    = sum_reg;
        if (take)
        begin
            if (q_item.kind == KIND_RESTART)
            begin
                sum_next = restart_sum;
            end
            else
            begin
                sum_next = sum_reg + SUM_W'(q_item.sample) - SUM_W'(q_item.old);
            end
        end
    end

    // near*256 + f*(far-near), rounded half up
    always_comb
    begin
        acc = (ACC_W'(p1_near_reg) <<< FRAC_W) + ACC_W'(p1_prod_reg)
            + ACC_W'(1 << (FRAC_W - 1));
        delayed_sel = p1_warming_reg ? cfg.init_value : acc[FRAC_W +: SAMPLE_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (adv)
            begin
                p1_valid_reg <= take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_warming_reg <= q_item.warming;
            p1_near_reg    <= q_item.tap_near;
            p1_prod_reg    <= PROD_W'(frac_s) * PROD_W'(q_item.tap_diff);
        end
    end

    // sum_reg belongs to the item in the interpolation stage; the ring size
    // is a power of two, so the floored average is the top of the sum
    always_comb
    begin
        out_push         = adv && p1_valid_reg;
        out_item.delayed = delayed_sel;
        out_item.average = sum_reg[SUM_W-1:AW];
        out_item.warming = p1_warming_reg;
    end

    `FDLA_CHECK(sum_in_range, (sum_reg >= SUM_LO) && (sum_reg <= SUM_HI),
                "running sum outside ring range")
    `FDLA_CHECK_NEXT(result_held, !adv && p1_valid_reg,
                     p1_valid_reg, "result dropped on stall")

endmodule

// ===== hw/rtl/fractional_delay_line_with_average_top.sv =====
// ----------------------------------------------------------------------------
// fractional_delay_line_with_average_top
// Fractional delay line with linear interpolation and a ring moving average.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload          transaction
//  -------   -------------------  ---------------  ------------------------
//  input     push / full          item (item_t)    push && !full
//  result    pop / empty          result (result_t) pop && !empty
//  config    cfg_write            cfg_index, data  cfg_write
//
//  One item per cycle sustained while results are taken as they arrive; the
//  ring takes one write and three reads per cycle from three RAM copies, and
//  the back part is a single interpolation stage. A result passes the RAM
//  read, mid queue, interpolation and output queue on its way to the ports.
//  Reset clears position, fill count and sum at once; no clearing pass, as
//  ring slots beyond the fill count read as the last fill value.
//  A stalled result holds the back part; the front stalls only when the mid
//  queue, counting the item in the RAM read, is full.
// ----------------------------------------------------------------------------
module fractional_delay_line_with_average_top #(
    parameter int DEPTH = fdla_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  fdla_pkg::item_t                  item,
    output logic                             full,
    output logic                             empty,
    input  logic                             pop,
    output fdla_pkg::result_t                result,
    input  logic                             cfg_write,
    input  logic [fdla_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fdla_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import fdla_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic                   mid_push;
    work_t                  mid_in;
    logic [$bits(work_t)-1:0] mid_out;
    logic                   mid_pop;
    logic                   mid_empty;
    logic [MID_LEVEL_W-1:0] mid_level;

    logic                       out_push;
    result_t                    out_in;
    logic [$bits(result_t)-1:0] out_data;
    logic [OUT_LEVEL_W-1:0]     out_level;

    // register file: writes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_DELAY_WHOLE:    cfg_next.delay_whole    = cfg_data[WHOLE_W-1:0];
                CFG_DELAY_FRACTION: cfg_next.delay_fraction = cfg_data[FRAC_W-1:0];
                CFG_INIT_VALUE:     cfg_next.init_value     = $signed(cfg_data[SAMPLE_W-1:0]);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept, classify against the fill count, read the taps
    fdla_front #(.DEPTH(DEPTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .cfg     (cfg_reg),
        .q_push  (mid_push),
        .q_item  (mid_in),
        .q_level (mid_level)
    );

    // decouple the tap reads from the arithmetic
    fdla_fifo #(.WIDTH($bits(work_t)), .DEPTH(MID_DEPTH)) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (mid_in),
        .pop       (mid_pop),
        .pop_data  (mid_out),
        .empty     (mid_empty),
        .level     (mid_level)
    );

    // back: interpolate, advance the running sum, shift out the average
    fdla_back #(.DEPTH(DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (mid_empty),
        .q_pop     (mid_pop),
        .q_item    (work_t'(mid_out)),
        .out_push  (out_push),
        .out_item  (out_in),
        .out_level (out_level)
    );

    // hold finished results until taken
    fdla_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_in),
        .pop       (pop),
        .pop_data  (out_data),
        .empty     (empty),
        .level     (out_level)
    );

    assign result = result_t'(out_data);

endmodule
